FILE: sv/gos_pkg.sv
// ----------------------------------------------------------------------------
// gos_pkg: shared types and constants of the gradient orientation similarity
// unit. Field widths, queue entry layout, register map and sequencer states.
// ----------------------------------------------------------------------------
package gos_pkg;

   localparam int GradWidth    = 16;
   localparam int SqWidth      = 32;   // gx*gx + gy*gy
   localparam int MagWidth     = 16;   // floor sqrt of SqWidth bits
   localparam int ThreshWidth  = 17;
   localparam int CountWidth   = 21;
   localparam int SumWidth     = 38;
   localparam int SimWidth     = 18;
   localparam int TermWidth    = 18;
   localparam int ProdWidth    = 32;
   localparam int NumWidth     = 39;   // term_sum + divisor/2
   localparam int StepWidth    = 6;
   localparam int AddrWidth    = 4;
   localparam int DataWidth    = 32;

   localparam logic [TermWidth-1:0]  TermMax  = 18'd131072;
   localparam logic [SumWidth-1:0]   SumMax   = {SumWidth{1'b1}};
   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

   // register indexes (paddr[3:2])
   localparam logic [1:0] RegFixedThresh  = 2'd0;
   localparam logic [1:0] RegMovingThresh = 2'd1;
   localparam logic [1:0] RegMinPixels    = 2'd2;
   localparam logic [1:0] RegUnused       = 2'd3;

   typedef struct packed {
      logic [SqWidth-1:0] sq_fixed;
      logic [SqWidth-1:0] sq_moving;
      logic               dot_neg;
      logic [SqWidth-1:0] dot_mag;
      logic               last;
   } gos_entry_type;

   typedef struct packed {
      logic [ThreshWidth-1:0] fixed_thresh;
      logic [ThreshWidth-1:0] moving_thresh;
      logic [CountWidth-1:0]  min_pixels;
   } gos_cfg_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SQRT  = 8'b0000_0010,
      ST_PROD  = 8'b0000_0100,
      ST_TSET  = 8'b0000_1000,
      ST_TERM  = 8'b0001_0000,
      ST_ACCUM = 8'b0010_0000,
      ST_DSET  = 8'b0100_0000,
      ST_DIV   = 8'b1000_0000
   } gos_state_type;

endpackage

FILE: sv/gos_channels.sv
// ----------------------------------------------------------------------------
// gos channels: valid/ready interfaces for the pixel and result streams.
// ----------------------------------------------------------------------------
interface gos_req_if
   import gos_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [GradWidth-1:0] fixed_grad_x;
   logic signed [GradWidth-1:0] fixed_grad_y;
   logic signed [GradWidth-1:0] moving_grad_x;
   logic signed [GradWidth-1:0] moving_grad_y;
   logic                        last_pixel;

   modport source (output valid, fixed_grad_x, fixed_grad_y, moving_grad_x,
                   moving_grad_y, last_pixel, input ready);
   modport sink   (input valid, fixed_grad_x, fixed_grad_y, moving_grad_x,
                   moving_grad_y, last_pixel, output ready);
endinterface

interface gos_rsp_if
   import gos_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [SimWidth-1:0]   similarity;
   logic [CountWidth-1:0] pixels_used;

   modport source (output valid, similarity, pixels_used, input ready);
   modport sink   (input valid, similarity, pixels_used, output ready);
endinterface

FILE: sv/gos_front.sv
// ----------------------------------------------------------------------------
// gos_front: pixel intake
// Registers one pixel, forms both squared magnitudes and the dot product,
// and pushes the result into the work queue.
// ----------------------------------------------------------------------------
module gos_front
   import gos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   gos_req_if.sink       req_chan,
   output logic          push,
   input  logic          full,
   output gos_entry_type push_entry
);

   logic                        valid_ff, valid_in;
   logic signed [GradWidth-1:0] fx_ff, fy_ff, mx_ff, my_ff;
   logic                        last_ff;
   logic signed [2*GradWidth-1:0] pfx, pfy, pmx, pmy, pdx, pdy;
   logic signed [SqWidth:0]       dot;
   logic                          take;

   assign push          = valid_ff && !full;
   assign req_chan.ready = !valid_ff || !full;
   assign take          = req_chan.valid && req_chan.ready;

   // products from the held pixel
   always_comb begin
      pfx = fx_ff * fx_ff;
      pfy = fy_ff * fy_ff;
      pmx = mx_ff * mx_ff;
      pmy = my_ff * my_ff;
      pdx = fx_ff * mx_ff;
      pdy = fy_ff * my_ff;
      dot = (SqWidth+1)'(pdx) + (SqWidth+1)'(pdy);
      push_entry.sq_fixed  = $unsigned(pfx) + $unsigned(pfy);
      push_entry.sq_moving = $unsigned(pmx) + $unsigned(pmy);
      push_entry.dot_neg   = dot[SqWidth];
      push_entry.dot_mag   = dot[SqWidth] ? SqWidth'(-dot) : dot[SqWidth-1:0];
      push_entry.last      = last_ff;
   end

   // hold the pixel until the queue takes it
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         fx_ff   <= req_chan.fixed_grad_x;
         fy_ff   <= req_chan.fixed_grad_y;
         mx_ff   <= req_chan.moving_grad_x;
         my_ff   <= req_chan.moving_grad_y;
         last_ff <= req_chan.last_pixel;
      end
   end

endmodule

FILE: sv/gos_queue.sv
// ----------------------------------------------------------------------------
// gos_queue: two-entry work queue
// Decouples the pixel intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
module gos_queue
   import gos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  gos_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output gos_entry_type pop_entry
);

   gos_entry_type slot_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    fill_ff;

   assign full      = fill_ff == 2'd2;
   assign empty     = fill_ff == 2'd0;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/gos_back.sv
// ----------------------------------------------------------------------------
// gos_back: arithmetic sequencer
// Per pixel: two bit-serial square roots, threshold test, magnitude product,
// bit-serial 1 - cos division and saturating accumulation. On the last pixel:
// bit-serial mean division and result register.
// ----------------------------------------------------------------------------
module gos_back
   import gos_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   output logic          pop,
   input  gos_entry_type pop_entry,
   input  gos_cfg_type   cfg,
   gos_rsp_if.source     rsp_chan
);

   gos_state_type          state_ff, state_in;
   gos_entry_type          ent_ff;
   logic [StepWidth-1:0]   step_ff;
   logic [SqWidth-1:0]     fsrc_ff, msrc_ff;
   logic [MagWidth+2:0]    frem_ff, mrem_ff;
   logic [MagWidth-1:0]    froot_ff, mroot_ff;
   logic [ProdWidth-1:0]   prod_ff;
   logic                   used_ff;
   logic [ProdWidth-1:0]   r_ff;
   logic [TermWidth-1:0]   q_ff;
   logic [SumWidth-1:0]    sum_ff;
   logic [CountWidth-1:0]  count_ff;
   logic [NumWidth-1:0]    num_ff;
   logic [CountWidth-1:0]  drem_ff, divisor_ff;
   logic                   zero_div_ff;
   logic                   rsp_valid_ff;
   logic [SimWidth-1:0]    sim_ff;
   logic [CountWidth-1:0]  used_out_ff;

   // square root step signals
   logic [MagWidth+2:0]    frem_t, mrem_t, ftrial, mtrial;
   // term step signals
   logic [ProdWidth:0]     r2;
   logic [TermWidth-1:0]   term_rnd, term;
   logic [SumWidth:0]      sum_add;
   // mean step signals
   logic [CountWidth:0]    drem_t;
   logic [CountWidth-1:0]  div_sel;
   logic [NumWidth-1:0]    quot;
   logic                   out_free;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.similarity  = sim_ff;
   assign rsp_chan.pixels_used = used_out_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (state_ff == ST_IDLE) && !empty;

   always_comb begin
      frem_t   = {frem_ff[MagWidth:0], fsrc_ff[SqWidth-1 -: 2]};
      mrem_t   = {mrem_ff[MagWidth:0], msrc_ff[SqWidth-1 -: 2]};
      ftrial   = {1'b0, froot_ff, 2'b01};
      mtrial   = {1'b0, mroot_ff, 2'b01};
      r2       = {r_ff, 1'b0};
      term_rnd = q_ff + TermWidth'(r2 >= {1'b0, prod_ff});
      term     = (term_rnd > TermMax) ? TermMax : term_rnd;
      sum_add  = {1'b0, sum_ff} + (SumWidth+1)'(term);
      drem_t   = {drem_ff, num_ff[NumWidth-1]};
      div_sel  = (count_ff > cfg.min_pixels) ? count_ff : cfg.min_pixels;
      quot     = num_ff;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!empty) state_in = ST_SQRT;
         ST_SQRT:  if (step_ff == '0) state_in = ST_PROD;
         ST_PROD:  state_in = ST_TSET;
         ST_TSET:  begin
            if (!used_ff) begin
               state_in = ST_ACCUM;
            end else if (ent_ff.dot_mag >= prod_ff) begin
               state_in = ST_ACCUM;
            end else begin
               state_in = ST_TERM;
            end
         end
         ST_TERM:  if (step_ff == '0) state_in = ST_ACCUM;
         ST_ACCUM: state_in = ent_ff.last ? ST_DSET : ST_IDLE;
         ST_DSET:  state_in = ST_DIV;
         ST_DIV:   if (step_ff == '0 && out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // raise the result on the final divide step, drop it after the transfer
         if (state_ff == ST_DIV && step_ff == '0 && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            // accumulate a used pixel, saturating
            ST_ACCUM: begin
               if (used_ff) begin
                  sum_ff <= sum_add[SumWidth] ? SumMax : sum_add[SumWidth-1:0];
                  if (count_ff != CountMax) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            // deliver the mean and clear the frame state
            ST_DIV: begin
               if (step_ff == '0 && out_free) begin
                  sum_ff       <= '0;
                  count_ff     <= '0;
               end
            end
            default: begin
            end
         endcase
      end

      // datapath, no reset needed
      unique case (state_ff)
         // load a queued pixel
         ST_IDLE: begin
            ent_ff   <= pop_entry;
            fsrc_ff  <= pop_entry.sq_fixed;
            msrc_ff  <= pop_entry.sq_moving;
            frem_ff  <= '0;
            mrem_ff  <= '0;
            froot_ff <= '0;
            mroot_ff <= '0;
            step_ff  <= StepWidth'(MagWidth - 1);
         end
         // one root bit for each magnitude
         ST_SQRT: begin
            fsrc_ff <= fsrc_ff << 2;
            msrc_ff <= msrc_ff << 2;
            if (frem_t >= ftrial) begin
               frem_ff  <= frem_t - ftrial;
               froot_ff <= {froot_ff[MagWidth-2:0], 1'b1};
            end else begin
               frem_ff  <= frem_t;
               froot_ff <= {froot_ff[MagWidth-2:0], 1'b0};
            end
            if (mrem_t >= mtrial) begin
               mrem_ff  <= mrem_t - mtrial;
               mroot_ff <= {mroot_ff[MagWidth-2:0], 1'b1};
            end else begin
               mrem_ff  <= mrem_t;
               mroot_ff <= {mroot_ff[MagWidth-2:0], 1'b0};
            end
            step_ff <= step_ff - 1'b1;
         end
         // threshold test and magnitude product
         ST_PROD: begin
            prod_ff <= froot_ff * mroot_ff;
            used_ff <= (ThreshWidth'(froot_ff) > cfg.fixed_thresh) &&
                       (ThreshWidth'(mroot_ff) > cfg.moving_thresh);
         end
         // set up the term division, or settle a clamped term
         ST_TSET: begin
            step_ff <= StepWidth'(15);
            if (!ent_ff.dot_neg) begin
               q_ff <= '0;
               r_ff <= (ent_ff.dot_mag >= prod_ff) ? '0 : prod_ff - ent_ff.dot_mag;
            end else if (ent_ff.dot_mag >= prod_ff) begin
               q_ff <= TermMax;
               r_ff <= '0;
            end else begin
               q_ff <= TermWidth'(1);
               r_ff <= ent_ff.dot_mag;
            end
         end
         // one quotient bit of (P - D) / P
         ST_TERM: begin
            if (r_ff >= prod_ff - r_ff) begin
               r_ff <= r_ff - (prod_ff - r_ff);
               q_ff <= {q_ff[TermWidth-2:0], 1'b1};
            end else begin
               r_ff <= r_ff << 1;
               q_ff <= {q_ff[TermWidth-2:0], 1'b0};
            end
            step_ff <= step_ff - 1'b1;
         end
         // pick the divisor and round the numerator
         ST_DSET: begin
            divisor_ff  <= div_sel;
            zero_div_ff <= div_sel == '0;
            num_ff      <= NumWidth'(sum_ff) + NumWidth'(div_sel >> 1);
            drem_ff     <= '0;
            step_ff     <= StepWidth'(NumWidth);
         end
         // one quotient bit of the mean, then hold for the result register
         ST_DIV: begin
            if (step_ff != '0) begin
               num_ff <= num_ff << 1;
               if (drem_t >= {1'b0, divisor_ff}) begin
                  drem_ff   <= CountWidth'(drem_t - {1'b0, divisor_ff});
                  num_ff[0] <= 1'b1;
               end else begin
                  drem_ff <= drem_t[CountWidth-1:0];
               end
               step_ff <= step_ff - 1'b1;
            end else if (out_free) begin
               if (zero_div_ff) begin
                  sim_ff <= '0;
               end else begin
                  sim_ff <= (quot > NumWidth'(TermMax)) ? TermMax : quot[SimWidth-1:0];
               end
               used_out_ff <= count_ff;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: sv/gradient_orientation_similarity_unit.sv
// ----------------------------------------------------------------------------
// gradient_orientation_similarity_unit: gradient orientation similarity
// Mean of 1 - cos between fixed and moving gradients over a frame of pixels.
//
//   channel   dir  handshake               payload
//   req_chan  in   valid/ready             four Q12.4 gradients, last_pixel
//   rsp_chan  out  valid/ready             similarity Q2.16, pixels_used
//   csr       in   psel/penable/pwrite     three registers at 0x0, 0x4, 0x8
//
// In the sequencer a pixel passes load, the paired bit-serial square roots,
// threshold test and product, term setup, the bit-serial 1 - cos division
// and accumulate; a pixel that fails a threshold or has a clamped term skips
// the division. The last pixel of a frame adds the 39-bit mean division.
// Reset is synchronous; it clears the queue, sums and control state.
// A two-entry queue lets intake keep taking pixels while the sequencer works;
// a stalled result register holds the sequencer before it loads the mean.
// ----------------------------------------------------------------------------
module gradient_orientation_similarity_unit
   import gos_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   gos_req_if.sink              req_chan,
   gos_rsp_if.source            rsp_chan,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready
);

   gos_cfg_type   cfg_ff;
   gos_entry_type push_entry, pop_entry;
   logic          push, full, pop, empty, wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            RegFixedThresh:  cfg_ff.fixed_thresh  <= pwdata[ThreshWidth-1:0];
            RegMovingThresh: cfg_ff.moving_thresh <= pwdata[ThreshWidth-1:0];
            RegMinPixels:    cfg_ff.min_pixels    <= pwdata[CountWidth-1:0];
            RegUnused: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (paddr[3:2])
         RegFixedThresh:  prdata = DataWidth'(cfg_ff.fixed_thresh);
         RegMovingThresh: prdata = DataWidth'(cfg_ff.moving_thresh);
         RegMinPixels:    prdata = DataWidth'(cfg_ff.min_pixels);
         RegUnused:       prdata = '0;
      endcase
   end

   gos_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .full       (full),
      .push_entry (push_entry)
   );

   gos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .empty      (empty),
      .pop_entry  (pop_entry)
   );

   gos_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop       (pop),
      .pop_entry (pop_entry),
      .cfg       (cfg_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule
